// ===== src/ahtp_pkg.sv =====
//------------------------------------------------------------------------------
// ahtp_pkg
// Shared types and constants for the header tag parser.
//------------------------------------------------------------------------------
`default_nettype none
package ahtp_pkg;

  localparam int unsigned STANDARD_ITEMS = 5;
  localparam int unsigned IDX_W = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] field_number;
    logic [7:0]  data_value;
    logic        last_of_field;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_HEADER, PH_OBJ_HEAD, PH_STD_LEN, PH_STD_FIELD, PH_EXT_COUNT,
    PH_EXT_NAME_LEN, PH_EXT_NAME, PH_EXT_TYPE, PH_EXT_VALUE_LEN,
    PH_EXT_VALUE, PH_SKIP, PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_STD    = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] ST_FINISHED = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;

  // up to two results per byte: a data beat then a status
  typedef struct packed {
    logic      data_vld;
    out_item_t data;
    logic      stat_vld;
    out_item_t stat;
  } res_pair_t;

  function automatic logic [7:0] guid_header(input logic [3:0] p);
    logic [7:0] t [16];
    t = '{8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
          8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C};
    return t[p];
  endfunction

  function automatic logic [7:0] guid_content(input logic [3:0] p);
    logic [7:0] t [16];
    t = '{8'h33, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
          8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C};
    return t[p];
  endfunction

  function automatic logic [7:0] guid_extended(input logic [3:0] p);
    logic [7:0] t [16];
    t = '{8'h40, 8'hA4, 8'hD0, 8'hD2, 8'h07, 8'hE3, 8'hD2, 8'h11,
          8'h97, 8'hF0, 8'h00, 8'hA0, 8'hC9, 8'h5E, 8'hA8, 8'h50};
    return t[p];
  endfunction

endpackage
`default_nettype wire

// ===== src/ahtp_front.sv =====
//------------------------------------------------------------------------------
// ahtp_front
// Byte parser: walks the header and its objects, one byte a cycle while the
// queue has room, and produces the result pair for each accepted byte.
//------------------------------------------------------------------------------
`default_nettype none
module ahtp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ahtp_pkg::in_item_t  in_data,
  output logic                     q_push,
  output ahtp_pkg::res_pair_t      q_data,
  input  wire logic                q_full
);
  import ahtp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] hdr_rem_r, hdr_rem_nxt;
  logic [63:0] obj_rem_r, obj_rem_nxt;
  logic [15:0] lens_r [STANDARD_ITEMS];
  logic [15:0] lens_nxt [STANDARD_ITEMS];
  logic [19:0] sum_r, sum_nxt;
  logic [15:0] desc_r, desc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] item_r, item_nxt;

  logic        fire;
  logic [7:0]  b;
  logic        sent;
  res_pair_t   res;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign b        = in_data.data_byte;

  // next state and results for one byte
  always_comb begin
    logic [63:0] obj_dec;
    logic [63:0] sz;
    logic [15:0] v16;
    logic [15:0] ci;
    logic        found;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    flags_nxt   = flags_r;
    acc_nxt     = acc_r;
    hdr_rem_nxt = hdr_rem_r;
    obj_rem_nxt = obj_rem_r;
    lens_nxt    = lens_r;
    sum_nxt     = sum_r;
    desc_nxt    = desc_r;
    cnt_nxt     = cnt_r;
    item_nxt    = item_r;
    res         = '0;
    sent        = 1'b0;
    obj_dec     = obj_rem_r - 64'd1;
    sz          = acc_r | ({56'd0, b} << {pos_r[2:0], 3'b000});
    v16         = {b, acc_r[7:0]};
    ci          = '0;
    found       = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        pos_nxt = pos_r + 5'd1;
        if (pos_r < 5'd16) begin
          if (b != guid_header(pos_r[3:0])) flags_nxt[0] = 1'b0;
          if (pos_r == 5'd15) begin
            acc_nxt = '0;
            if (!flags_nxt[0]) begin
              res.stat_vld = 1'b1;
              res.stat.kind = KIND_STATUS;
              res.stat.status = ST_BAD_HDR;
              sent = 1'b1;
              phase_nxt = PH_DONE;
            end
          end
        end else if (pos_r < 5'd24) begin
          acc_nxt = sz;
        end
        if (pos_r == 5'd29) begin
          hdr_rem_nxt = (acc_r >= 64'd30) ? acc_r - 64'd30 : 64'd0;
          if (acc_r <= 64'd30) begin
            res.stat_vld = 1'b1;
            res.stat.kind = KIND_STATUS;
            res.stat.status = ST_FINISHED;
            sent = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_OBJ_HEAD;
            pos_nxt = '0;
            flags_nxt = 3'b111;
            acc_nxt = '0;
          end
        end
      end
      PH_OBJ_HEAD: begin
        pos_nxt = pos_r + 5'd1;
        if (pos_r < 5'd16) begin
          if (b != guid_content(pos_r[3:0]))  flags_nxt[1] = 1'b0;
          if (b != guid_extended(pos_r[3:0])) flags_nxt[2] = 1'b0;
        end else begin
          acc_nxt = sz;
        end
        if (pos_r == 5'd23) begin
          if (sz < 64'd24 || sz > hdr_rem_r) begin
            res.stat_vld = 1'b1;
            res.stat.kind = KIND_STATUS;
            res.stat.status = ST_OVERRUN;
            sent = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            hdr_rem_nxt = hdr_rem_r - sz;
            obj_rem_nxt = sz - 64'd24;
            pos_nxt = '0;
            acc_nxt = '0;
            if (sz == 64'd24) begin
              if (hdr_rem_r == sz) begin
                res.stat_vld = 1'b1;
                res.stat.kind = KIND_STATUS;
                res.stat.status = ST_FINISHED;
                sent = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_OBJ_HEAD;
                flags_nxt = 3'b111;
              end
            end else if (flags_r[1]) begin
              item_nxt = '0;
              sum_nxt = 20'(2 * STANDARD_ITEMS);
              phase_nxt = PH_STD_LEN;
            end else if (flags_r[2]) begin
              phase_nxt = PH_EXT_COUNT;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
      PH_DONE: ;
      default: begin
        obj_rem_nxt = obj_dec;
        unique case (phase_r)
          PH_STD_LEN: begin
            if (pos_r == 5'd0) begin
              acc_nxt = {56'd0, b};
              pos_nxt = 5'd1;
            end else begin
              acc_nxt = {48'd0, v16};
              pos_nxt = '0;
              if (item_r < 16'(STANDARD_ITEMS)) begin
                lens_nxt[item_r[IDX_W-1:0]] = v16;
                sum_nxt = sum_r + {4'd0, v16};
              end
              item_nxt = item_r + 16'd1;
              if (item_nxt >= 16'(STANDARD_ITEMS)) begin
                if ({44'd0, sum_nxt} == 64'(2 * STANDARD_ITEMS) + obj_dec) begin
                  // first field with nonzero length
                  for (int i = STANDARD_ITEMS - 1; i >= 0; i--)
                    if (lens_nxt[i] != 16'd0) begin
                      ci = 16'(i);
                      found = 1'b1;
                    end
                  item_nxt = found ? ci : 16'(STANDARD_ITEMS);
                  cnt_nxt = lens_nxt[ci[IDX_W-1:0]];
                  phase_nxt = found ? PH_STD_FIELD : PH_SKIP;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
          end
          PH_STD_FIELD: begin
            res.data_vld = 1'b1;
            res.data.kind = KIND_STD;
            res.data.field_number = item_r;
            res.data.data_value = b;
            res.data.last_of_field = (cnt_r == 16'd1);
            cnt_nxt = cnt_r - 16'd1;
            if (cnt_r == 16'd1) begin
              for (int i = STANDARD_ITEMS - 1; i >= 0; i--)
                if (16'(i) > item_r && lens_r[i] != 16'd0) begin
                  ci = 16'(i);
                  found = 1'b1;
                end
              item_nxt = found ? ci : 16'(STANDARD_ITEMS);
              cnt_nxt = lens_r[ci[IDX_W-1:0]];
              phase_nxt = found ? PH_STD_FIELD : PH_SKIP;
            end
          end
          PH_EXT_COUNT: begin
            if (pos_r == 5'd0) begin
              acc_nxt = {56'd0, b};
              pos_nxt = 5'd1;
            end else begin
              acc_nxt = {48'd0, v16};
              pos_nxt = '0;
              desc_nxt = v16;
              item_nxt = '0;
              phase_nxt = (v16 == 16'd0) ? PH_SKIP : PH_EXT_NAME_LEN;
            end
          end
          PH_EXT_NAME_LEN: begin
            if (pos_r == 5'd0) begin
              acc_nxt = {56'd0, b};
              pos_nxt = 5'd1;
            end else begin
              acc_nxt = {48'd0, v16};
              pos_nxt = '0;
              cnt_nxt = v16;
              phase_nxt = (v16 == 16'd0) ? PH_EXT_TYPE : PH_EXT_NAME;
            end
          end
          PH_EXT_NAME: begin
            if (cnt_r > 16'd2) begin
              res.data_vld = 1'b1;
              res.data.kind = KIND_NAME;
              res.data.field_number = item_r;
              res.data.data_value = b;
              res.data.last_of_field = (cnt_r == 16'd3);
            end
            cnt_nxt = cnt_r - 16'd1;
            if (cnt_r == 16'd1) begin
              pos_nxt = '0;
              phase_nxt = PH_EXT_TYPE;
            end
          end
          PH_EXT_TYPE: begin
            if (pos_r == 5'd0) begin
              acc_nxt = {56'd0, b};
              pos_nxt = 5'd1;
            end else begin
              acc_nxt = {48'd0, v16};
              pos_nxt = '0;
              phase_nxt = PH_EXT_VALUE_LEN;
            end
          end
          PH_EXT_VALUE_LEN: begin
            if (pos_r == 5'd0) begin
              acc_nxt = {56'd0, b};
              pos_nxt = 5'd1;
            end else begin
              acc_nxt = {48'd0, v16};
              pos_nxt = '0;
              cnt_nxt = v16;
              if (v16 == 16'd0) begin
                desc_nxt = desc_r - 16'd1;
                item_nxt = item_r + 16'd1;
                phase_nxt = (desc_r == 16'd1) ? PH_SKIP : PH_EXT_NAME_LEN;
              end else begin
                phase_nxt = PH_EXT_VALUE;
              end
            end
          end
          PH_EXT_VALUE: begin
            res.data_vld = 1'b1;
            res.data.kind = KIND_VALUE;
            res.data.field_number = item_r;
            res.data.data_value = b;
            res.data.last_of_field = (cnt_r == 16'd1);
            cnt_nxt = cnt_r - 16'd1;
            if (cnt_r == 16'd1) begin
              desc_nxt = desc_r - 16'd1;
              item_nxt = item_r + 16'd1;
              pos_nxt = '0;
              phase_nxt = (desc_r == 16'd1) ? PH_SKIP : PH_EXT_NAME_LEN;
            end
          end
          default: ;
        endcase
        // end of object body
        if (obj_dec == 64'd0) begin
          if (hdr_rem_r == 64'd0) begin
            res.stat_vld = 1'b1;
            res.stat.kind = KIND_STATUS;
            res.stat.status = ST_FINISHED;
            sent = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_OBJ_HEAD;
            pos_nxt = '0;
            flags_nxt = 3'b111;
            acc_nxt = '0;
          end
        end
      end
    endcase

    // end of stream: closing status if none was sent, then back to reset state
    if (in_data.end_of_stream) begin
      if (!sent && phase_nxt != PH_DONE) begin
        res.stat_vld = 1'b1;
        res.stat.kind = KIND_STATUS;
        res.stat.status = (phase_nxt == PH_HEADER) ? ST_BAD_HDR : ST_OVERRUN;
      end
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      flags_nxt   = 3'b111;
      acc_nxt     = '0;
      hdr_rem_nxt = '0;
      obj_rem_nxt = '0;
      for (int i = 0; i < STANDARD_ITEMS; i++) lens_nxt[i] = '0;
      sum_nxt     = '0;
      desc_nxt    = '0;
      cnt_nxt     = '0;
      item_nxt    = '0;
    end
  end

  assign q_push = fire && (res.data_vld || res.stat_vld);
  assign q_data = res;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      flags_r   <= 3'b111;
      acc_r     <= '0;
      hdr_rem_r <= '0;
      obj_rem_r <= '0;
      for (int i = 0; i < STANDARD_ITEMS; i++) lens_r[i] <= '0;
      sum_r     <= '0;
      desc_r    <= '0;
      cnt_r     <= '0;
      item_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      flags_r   <= flags_nxt;
      acc_r     <= acc_nxt;
      hdr_rem_r <= hdr_rem_nxt;
      obj_rem_r <= obj_rem_nxt;
      lens_r    <= lens_nxt;
      sum_r     <= sum_nxt;
      desc_r    <= desc_nxt;
      cnt_r     <= cnt_nxt;
      item_r    <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ahtp_queue.sv =====
//------------------------------------------------------------------------------
// ahtp_queue
// Two-entry queue of result pairs between the parser and the output stage.
//------------------------------------------------------------------------------
`default_nettype none
module ahtp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ahtp_pkg::res_pair_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output ahtp_pkg::res_pair_t       head,
  output logic                      not_empty
);
  import ahtp_pkg::*;

  res_pair_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/ahtp_back.sv =====
//------------------------------------------------------------------------------
// ahtp_back
// Output stage: unpacks each queued pair into one or two result beats.
//------------------------------------------------------------------------------
`default_nettype none
module ahtp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ahtp_pkg::res_pair_t  head,
  input  wire logic                 not_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ahtp_pkg::out_item_t       out_data
);
  import ahtp_pkg::*;

  // set once the data half of the head pair has gone out
  logic data_done_r, data_done_nxt;
  logic show_data;

  assign show_data = head.data_vld && !data_done_r;
  assign out_valid = not_empty;
  assign out_data  = show_data ? head.data : head.stat;

  always_comb begin
    pop = 1'b0;
    data_done_nxt = data_done_r;
    if (not_empty && out_ready) begin
      if (show_data && head.stat_vld) begin
        data_done_nxt = 1'b1;
      end else begin
        pop = 1'b1;
        data_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) data_done_r <= 1'b0;
    else        data_done_r <= data_done_nxt;
  end

endmodule
`default_nettype wire

// ===== src/asf_header_tag_parser.sv =====
//------------------------------------------------------------------------------
// asf_header_tag_parser
// Byte-serial walker of a media file header that emits content-description
// and extended-description field bytes plus a closing status.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid/in_ready     ahtp_pkg::in_item_t
//   out_     out  out_valid/out_ready   ahtp_pkg::out_item_t
//
// One byte is accepted per cycle while the queue is not full.
// A byte giving two results (data then status) goes out as two beats.
// Results pass a two-entry queue; in_ready drops only when it is full.
// Reset (rst_n low, synchronous) returns the parser to the header phase.
//------------------------------------------------------------------------------
`default_nettype none
module asf_header_tag_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ahtp_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ahtp_pkg::out_item_t       out_data
);
  import ahtp_pkg::*;

  logic      q_push, q_full, q_pop, q_ne;
  res_pair_t q_in, q_head;

  ahtp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  ahtp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head(q_head), .not_empty(q_ne)
  );

  ahtp_back u_back (
    .clk(clk), .rst_n(rst_n), .head(q_head), .not_empty(q_ne), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire
